// ===== design/sgb_pkg.sv =====
package sgb_pkg;

  // Accumulator and coefficient-sum widths cover up to 31 taps of 16-bit data.
  localparam int ACC_W = 29;
  localparam int DEN_W = 13;
  localparam int DV_W  = 29;
  localparam int TW    = 16;
  localparam int RW    = 17;
  localparam int QCW   = 5;

  localparam logic [2:0] CFG_RADIUS = 3'd0;
  localparam logic [2:0] CFG_COEF   = 3'd1;
  localparam logic [2:0] CFG_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_HEIGHT = 3'd3;
  localparam logic [2:0] CFG_COMPS  = 3'd4;

  localparam logic [2:0]  RST_RADIUS = 3'd1;
  localparam logic [63:0] RST_COEF   = 64'd13209;
  localparam logic [10:0] RST_WIDTH  = 11'd1024;
  localparam logic [15:0] RST_HEIGHT = 16'd1024;
  localparam logic [2:0]  RST_COMPS  = 3'd4;

  localparam logic [QCW-1:0] DIV_BITS_V = 5'd8;
  localparam logic [QCW-1:0] DIV_BITS_H = 5'd16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_V_TAP,
    ST_V_FLUSH,
    ST_V_DIVI,
    ST_V_DIV,
    ST_V_OUT,
    ST_RAW,
    ST_H_PIX,
    ST_H_TAP,
    ST_H_FLUSH,
    ST_H_DIVI,
    ST_H_DIV,
    ST_H_WR
  } state_t;

  typedef struct packed {
    logic latch;
    logic hmode;
    logic tap_start;
    logic tap_step;
    logic div_start;
    logic div_step;
    logic out_load;
    logic raw_wr;
    logic hx_init;
    logic hx_inc;
    logic hb_wr;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic has_out;
    logic has_in;
    logic eol;
    logic tap_last;
    logic div_last;
    logic out_free;
    logic hx_last;
  } sts_t;

endpackage

// ===== design/separable_gaussian_blur_unit.sv =====
// One item at a time. An item that yields a result runs a tap walk over the line
// store across n = 2R+1 taps clipped at the frame edge, then an 8-step divider,
// then waits until the output register is free before it is loaded.
// An item closing an input line then runs the horizontal pass, pixel by pixel. Synchronous
// active-low reset restores the register defaults and the frame start; line stores
// are not cleared.
module separable_gaussian_blur_unit
  import sgb_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 7,
  parameter int LANES      = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // comp0, comp1, comp2, comp3
  input  logic        in_tuser,   // drain
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // out0, out1, out2, out3
  output logic        out_tlast,  // frame_end
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [63:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  sgb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sgb_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS),
    .LANES      (LANES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== design/sgb_ctrl.sv =====
module sgb_ctrl
  import sgb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          if (sts.has_out) begin
            cmd.tap_start = 1'b1;
            state_nxt     = ST_V_TAP;
          end else begin
            state_nxt = ST_RAW;
          end
        end
      end
      ST_V_TAP: begin
        cmd.tap_step = 1'b1;
        if (sts.tap_last) begin
          state_nxt = ST_V_FLUSH;
        end
      end
      ST_V_FLUSH: state_nxt = ST_V_DIVI;
      ST_V_DIVI: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_V_DIV;
      end
      ST_V_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_V_OUT;
        end
      end
      ST_V_OUT: begin
        // hold until the output register is free
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_RAW;
        end
      end
      ST_RAW: begin
        cmd.raw_wr = sts.has_in;
        if (sts.has_in && sts.eol) begin
          cmd.hx_init = 1'b1;
          state_nxt   = ST_H_PIX;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      ST_H_PIX: begin
        cmd.hmode     = 1'b1;
        cmd.tap_start = 1'b1;
        state_nxt     = ST_H_TAP;
      end
      ST_H_TAP: begin
        cmd.hmode    = 1'b1;
        cmd.tap_step = 1'b1;
        if (sts.tap_last) begin
          state_nxt = ST_H_FLUSH;
        end
      end
      ST_H_FLUSH: begin
        cmd.hmode = 1'b1;
        state_nxt = ST_H_DIVI;
      end
      ST_H_DIVI: begin
        cmd.hmode     = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt     = ST_H_DIV;
      end
      ST_H_DIV: begin
        cmd.hmode    = 1'b1;
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_H_WR;
        end
      end
      ST_H_WR: begin
        cmd.hmode  = 1'b1;
        cmd.hb_wr  = 1'b1;
        if (sts.hx_last) begin
          cmd.advance = 1'b1;
          state_nxt   = ST_IDLE;
        end else begin
          cmd.hx_inc = 1'b1;
          state_nxt  = ST_H_PIX;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== design/sgb_datapath.sv =====
module sgb_datapath
  import sgb_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 7,
  parameter int LANES      = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [31:0] in_tdata,
  input  logic        in_tuser,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [63:0] cfg_wdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  output logic        out_tlast
);

  localparam int XW       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW       = $clog2(MAX_WIDTH + 1);
  localparam int WCW      = (WW > 11) ? WW : 11;
  localparam int HROWS    = 2 * MAX_RADIUS + 2;
  localparam int RB       = $clog2(HROWS);
  localparam int HB_DEPTH = (1 << RB) << XW;
  localparam int RADW     = $clog2(MAX_RADIUS + 1);
  localparam int RCW      = (RADW > 3) ? RADW : 3;
  localparam int PX_W     = LANES * 8;
  localparam int HB_W     = LANES * 16;

  // configuration
  logic [2:0]  radius_r;
  logic [63:0] coef_r;
  logic [10:0] width_r;
  logic [15:0] height_r;
  logic [2:0]  comps_r;
  logic        cfg_hit;

  assign cfg_hit = cfg_we && (cfg_addr <= CFG_COMPS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RST_RADIUS;
      coef_r   <= RST_COEF;
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
      comps_r  <= RST_COMPS;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_RADIUS: radius_r <= cfg_wdata[2:0];
        CFG_COEF:   coef_r   <= cfg_wdata;
        CFG_WIDTH:  width_r  <= cfg_wdata[10:0];
        CFG_HEIGHT: height_r <= cfg_wdata[15:0];
        CFG_COMPS:  comps_r  <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // clamped register values
  logic [RCW-1:0]  rad_x;
  logic [RADW-1:0] rad_e;
  logic [WCW-1:0]  wid_x;
  logic [WW-1:0]   w_e;
  logic [WW-1:0]   wm1;
  logic [15:0]     h_e;
  logic [2:0]      lanes_e;

  always_comb begin
    rad_x = RCW'(radius_r);
    if (rad_x == '0) begin
      rad_e = RADW'(1);
    end else if (rad_x > RCW'(MAX_RADIUS)) begin
      rad_e = RADW'(MAX_RADIUS);
    end else begin
      rad_e = rad_x[RADW-1:0];
    end
    wid_x = WCW'(width_r);
    if (wid_x == '0) begin
      w_e = WW'(1);
    end else if (wid_x > WCW'(MAX_WIDTH)) begin
      w_e = WW'(MAX_WIDTH);
    end else begin
      w_e = wid_x[WW-1:0];
    end
    h_e = (height_r == 16'd0) ? 16'd1 : height_r;
    if (comps_r == 3'd0) begin
      lanes_e = 3'd1;
    end else if (comps_r > 3'(LANES)) begin
      lanes_e = 3'(LANES);
    end else begin
      lanes_e = comps_r;
    end
  end

  assign wm1 = w_e - WW'(1);

  // stream position
  logic [XW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [RW-1:0] rad_r17;
  logic          eol;
  logic          has_out;
  logic          has_in;
  logic          frame_done;
  logic [TW-1:0] y;

  assign rad_r17    = RW'(rad_e);
  assign eol        = (WW'(col_r) == wm1);
  assign has_out    = (row_r > rad_r17);
  assign has_in     = (row_r < RW'(h_e));
  assign frame_done = has_out && eol && (row_r == (RW'(h_e) + rad_r17));
  assign y          = TW'(row_r - rad_r17 - RW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cfg_hit) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.advance) begin
      if (frame_done) begin
        col_r <= '0;
        row_r <= '0;
      end else if (eol) begin
        col_r <= '0;
        row_r <= row_r + RW'(1);
      end else begin
        col_r <= col_r + XW'(1);
      end
    end
  end

  logic [PX_W-1:0] px_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      px_r <= in_tuser ? '0 : in_tdata[PX_W-1:0];
    end
  end

  // column of the horizontal pass
  logic [XW-1:0] xh_r;
  logic          hx_last;

  assign hx_last = (WW'(xh_r) == wm1);

  always_ff @(posedge clk) begin
    if (cmd.hx_init) begin
      xh_r <= '0;
    end else if (cmd.hx_inc) begin
      xh_r <= xh_r + XW'(1);
    end
  end

  // tap walker
  logic [TW-1:0] ctr;
  logic [TW-1:0] lim;
  logic [TW-1:0] lo;
  logic [TW:0]   hsum;
  logic [TW-1:0] hi;
  logic [TW-1:0] t_r;
  logic [TW-1:0] hi_r;
  logic [TW-1:0] ctr_r;
  logic [TW-1:0] tap_dist;
  logic [7:0]    coef;
  logic [7:0]    coef_d_r;
  logic          vld_d_r;

  always_comb begin
    ctr      = cmd.hmode ? TW'(xh_r) : y;
    lim      = cmd.hmode ? TW'(wm1) : (h_e - 16'd1);
    lo       = (ctr > TW'(rad_e)) ? (ctr - TW'(rad_e)) : '0;
    hsum     = {1'b0, ctr} + (TW + 1)'(rad_e);
    hi       = (hsum < {1'b0, lim}) ? hsum[TW-1:0] : lim;
    tap_dist = (t_r > ctr_r) ? (t_r - ctr_r) : (ctr_r - t_r);
    coef     = (tap_dist < TW'(8)) ? coef_r[{tap_dist[2:0], 3'b000} +: 8] : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (cmd.tap_start) begin
      t_r   <= lo;
      hi_r  <= hi;
      ctr_r <= ctr;
    end else if (cmd.tap_step) begin
      t_r <= t_r + TW'(1);
    end
    coef_d_r <= coef;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_d_r <= 1'b0;
    end else begin
      vld_d_r <= cmd.tap_step;
    end
  end

  // line stores
  logic [PX_W-1:0] raw_mem [0:MAX_WIDTH-1];
  logic [HB_W-1:0] hb_mem  [0:HB_DEPTH-1];
  logic [PX_W-1:0] raw_rd_r;
  logic [HB_W-1:0] hb_rd_r;
  logic [HB_W-1:0] hb_wdata;

  always_ff @(posedge clk) begin
    if (cmd.raw_wr) begin
      raw_mem[col_r] <= px_r;
    end
    if (cmd.tap_step) begin
      raw_rd_r <= raw_mem[t_r[XW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hb_wr) begin
      hb_mem[{row_r[RB-1:0], xh_r}] <= hb_wdata;
    end
    if (cmd.tap_step) begin
      hb_rd_r <= hb_mem[{t_r[RB-1:0], col_r}];
    end
  end

  // accumulate, divide
  logic [DEN_W-1:0] den_r;
  logic [DV_W-1:0]  dsh_r;
  logic [QCW-1:0]   div_cnt_r;
  logic             zero_r;
  logic [15:0]      res16 [LANES];
  logic [7:0]       res8  [LANES];

  always_ff @(posedge clk) begin
    if (cmd.tap_start) begin
      den_r <= '0;
    end else if (vld_d_r) begin
      den_r <= den_r + DEN_W'(coef_d_r);
    end
    if (cmd.div_start) begin
      dsh_r     <= DV_W'({den_r, 15'd0});
      div_cnt_r <= cmd.hmode ? DIV_BITS_H : DIV_BITS_V;
      zero_r    <= (den_r == '0);
    end else if (cmd.div_step) begin
      dsh_r     <= dsh_r >> 1;
      div_cnt_r <= div_cnt_r - QCW'(1);
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [ACC_W-1:0] acc_r;
    logic [15:0]      opnd;
    logic [23:0]      prod;
    logic [DV_W-1:0]  num;
    logic [DV_W-1:0]  rem_r;
    logic [15:0]      q_r;
    logic             sat_r;

    assign opnd = cmd.hmode ? {8'd0, raw_rd_r[8*l +: 8]} : hb_rd_r[16*l +: 16];
    assign prod = coef_d_r * opnd;
    assign num  = cmd.hmode ? {acc_r[ACC_W-9:0], 8'd0} : acc_r;

    always_ff @(posedge clk) begin
      if (cmd.tap_start) begin
        acc_r <= '0;
      end else if (vld_d_r) begin
        acc_r <= acc_r + ACC_W'(prod);
      end
      if (cmd.div_start) begin
        rem_r <= num;
        q_r   <= '0;
        sat_r <= (num >= DV_W'({den_r, 16'd0}));
      end else if (cmd.div_step) begin
        if (rem_r >= dsh_r) begin
          rem_r <= rem_r - dsh_r;
          q_r   <= {q_r[14:0], 1'b1};
        end else begin
          q_r <= {q_r[14:0], 1'b0};
        end
      end
    end

    assign res16[l] = zero_r ? 16'd0 : (sat_r ? 16'hFFFF : q_r);
    assign res8[l]  = zero_r ? 8'd0 : (sat_r ? 8'hFF : q_r[7:0]);
    assign hb_wdata[16*l +: 16] = res16[l];
  end

  // output register
  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic        out_last_r;
  logic [31:0] out_word;

  always_comb begin
    out_word = '0;
    for (int l = 0; l < LANES; l++) begin
      if (3'(l) < lanes_e) begin
        out_word[8*l +: 8] = res8[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_data_r <= out_word;
      out_last_r <= frame_done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  assign sts.has_out  = has_out;
  assign sts.has_in   = has_in;
  assign sts.eol      = eol;
  assign sts.tap_last = (t_r == hi_r);
  assign sts.div_last = (div_cnt_r == QCW'(1));
  assign sts.out_free = !out_valid_r || out_tready;
  assign sts.hx_last  = hx_last;

endmodule

// ===== tb/tb_separable_gaussian_blur_unit.sv =====
module tb_separable_gaussian_blur_unit;
  import sgb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXW  = 1024;
  localparam int MAXR  = 7;
  localparam int NLANE = 4;
  localparam int RING  = 2 * MAXR + 2;

  typedef struct packed {
    logic [31:0] pix;
    logic        last;
  } blur_px_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = CFG_RADIUS;
  logic [63:0] cfg_wdata = '0;

  separable_gaussian_blur_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic [2:0]  rad_reg;
  logic [63:0] coef_reg;
  logic [10:0] width_reg;
  logic [15:0] height_reg;
  logic [2:0]  comps_reg;
  logic [31:0] line_buf [MAXW];
  logic [63:0] hblur_ring [RING][MAXW];
  int          col_pos;
  int          row_pos;

  blur_px_t expected_px[$];
  int       err_cnt = 0;
  int       items_sent = 0;
  int       hold_cycles = 0;
  bit       quiet = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #60ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int cur_radius();
    return (rad_reg < 1) ? 1 : ((rad_reg > MAXR) ? MAXR : int'(rad_reg));
  endfunction

  function automatic int cur_width();
    return (width_reg < 1) ? 1 : ((width_reg > MAXW) ? MAXW : int'(width_reg));
  endfunction

  function automatic int cur_height();
    return (height_reg < 1) ? 1 : int'(height_reg);
  endfunction

  function automatic int cur_lanes();
    return (comps_reg < 1) ? 1 : ((comps_reg > NLANE) ? NLANE : int'(comps_reg));
  endfunction

  function automatic longint unsigned coef_at(int d);
    if (d > 7) return 0;
    return (coef_reg >> (8 * d)) & 64'hFF;
  endfunction

  function automatic void model_config(logic [2:0] idx, logic [63:0] val);
    case (idx)
      CFG_RADIUS: rad_reg = val[2:0];
      CFG_COEF:   coef_reg = val;
      CFG_WIDTH:  width_reg = val[10:0];
      CFG_HEIGHT: height_reg = val[15:0];
      CFG_COMPS:  comps_reg = val[2:0];
      default: return;
    endcase
    col_pos = 0;
    row_pos = 0;
  endfunction

  // horizontal pass over the finished line into its ring slot
  function automatic void hblur_line(int slot, int w, int rad);
    longint unsigned num [4];
    longint unsigned den, c, hv;
    logic [63:0] word;
    int lo, hi;
    for (int x = 0; x < w; x++) begin
      lo = (x > rad) ? x - rad : 0;
      hi = (x + rad < w - 1) ? x + rad : w - 1;
      num = '{0, 0, 0, 0};
      den = 0;
      for (int xx = lo; xx <= hi; xx++) begin
        c = coef_at((xx > x) ? xx - x : x - xx);
        for (int i = 0; i < 4; i++) num[i] += c * line_buf[xx][8*i +: 8];
        den += c;
      end
      word = '0;
      for (int i = 0; i < 4; i++) begin
        hv = (den != 0) ? (num[i] << 8) / den : 0;
        if (hv > 64'hFFFF) hv = 64'hFFFF;
        word[16*i +: 16] = hv[15:0];
      end
      hblur_ring[slot][x] = word;
    end
  endfunction

  function automatic void predict_blur(logic [31:0] data, logic drn);
    int w, h, rad, lanes, x, r, y, lo, hi;
    longint unsigned num [4];
    longint unsigned den, c, ov;
    blur_px_t res;
    bit fin;
    w = cur_width();
    h = cur_height();
    rad = cur_radius();
    lanes = cur_lanes();
    x = col_pos;
    r = row_pos;
    fin = 0;
    if (r >= rad + 1) begin
      y = r - rad - 1;
      lo = (y > rad) ? y - rad : 0;
      hi = (y + rad < h - 1) ? y + rad : h - 1;
      num = '{0, 0, 0, 0};
      den = 0;
      for (int yy = lo; yy <= hi; yy++) begin
        c = coef_at((yy > y) ? yy - y : y - yy);
        for (int i = 0; i < 4; i++) num[i] += c * hblur_ring[yy % RING][x][16*i +: 16];
        den += c;
      end
      res = '0;
      for (int i = 0; i < 4; i++) begin
        ov = (den != 0) ? num[i] / (den << 8) : 0;
        if (ov > 255) ov = 255;
        if (i < lanes) res.pix[8*i +: 8] = ov[7:0];
      end
      fin = (x == w - 1) && (y == h - 1);
      res.last = fin;
      expected_px.push_back(res);
    end
    if (r < h) begin
      line_buf[x] = drn ? 32'd0 : data;
      if (x == w - 1) hblur_line(r % RING, w, rad);
    end
    if (fin) begin
      col_pos = 0;
      row_pos = 0;
    end else if (x + 1 < w) begin
      col_pos = x + 1;
    end else begin
      col_pos = 0;
      row_pos = r + 1;
    end
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // result checker
  always @(posedge clk) begin
    blur_px_t exp_px;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_px.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h last %b", out_tdata, out_tlast));
      end else begin
        exp_px = expected_px.pop_front();
        for (int i = 0; i < 4; i++)
          if (out_tdata[8*i +: 8] !== exp_px.pix[8*i +: 8])
            report_mismatch($sformatf("out%0d got %h want %h", i, out_tdata[8*i +: 8],
                                      exp_px.pix[8*i +: 8]));
        if (out_tlast !== exp_px.last)
          report_mismatch($sformatf("frame_end got %b want %b", out_tlast, exp_px.last));
      end
    end
  end

  // result side: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet || ($urandom_range(99) >= 13);
    end
  end

  task automatic send_item(logic [31:0] data, logic drn);
    in_tvalid <= 1'b1;
    in_tdata <= data;
    in_tuser <= drn;
    do @(posedge clk); while (!in_tready);
    predict_blur(data, drn);
    items_sent++;
    if (!quiet && $urandom_range(99) < 13) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk);
    // a line close may still be running with nothing expected
    repeat (cur_width() * 40 + 100) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_config(idx, val);
  endtask

  task automatic setup_frame(int rad, logic [63:0] coef, int w, int h, int comps);
    wait_idle();
    write_reg(CFG_RADIUS, rad);
    write_reg(CFG_COEF, coef);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_COMPS, comps);
  endtask

  // pixel rows then drain rows; noise swaps the drain flag now and then
  task automatic send_frame(int noise_pct, int rows_to_send = -1);
    int total;
    bit in_drain;
    total = (rows_to_send < 0) ? cur_height() + cur_radius() + 1 : rows_to_send;
    for (int rr = 0; rr < total; rr++)
      for (int x = 0; x < cur_width(); x++) begin
        in_drain = (rr >= cur_height());
        if ($urandom_range(99) < noise_pct) in_drain = !in_drain;
        send_item($urandom(), in_drain);
      end
  endtask

  function automatic logic [63:0] gaussian_coef(int rad);
    logic [63:0] cw;
    int v;
    cw = '0;
    v = $urandom_range(255, 60);
    for (int k = 0; k <= rad; k++) begin
      cw[8*k +: 8] = v;
      v = v * $urandom_range(90, 40) / 100;
    end
    return cw;
  endfunction

  task automatic test_reset_defaults();
    // default kernel, full-size frame: the first items give nothing
    for (int i = 0; i < 6; i++) send_item($urandom(), 1'b0);
  endtask

  task automatic test_directed();
    setup_frame(1, 64'h3399, 3, 2, 4);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'h00FF_FF00, 1'b0);
    send_item(32'hFF00_00FF, 1'b1);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'h8040_2010, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b1);
    for (int i = 0; i < 4; i++) send_item(32'h0000_0000, 1'b1);
    // clamped registers, zero kernel, saturating kernel
    setup_frame(0, 64'h0, 2, 1, 0);
    send_frame(0);
    setup_frame(7, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 7);
    send_frame(0);
    setup_frame(1, 64'h0000_0000_0000_FF01, 2047, 1, 3);
    write_reg(CFG_HEIGHT, 16'hFFFF);
    write_reg(CFG_WIDTH, 2);
    write_reg(CFG_HEIGHT, 2);
    send_frame(0);
  endtask

  task automatic test_wide_line();
    setup_frame(1, 64'h40C0, 256, 1, 4);
    send_frame(2);
  endtask

  task automatic test_config_mid_frame();
    setup_frame(2, gaussian_coef(2), 5, 4, 2);
    send_frame(0, 4);
    wait_idle();
    write_reg(CFG_RADIUS, 3);
    send_frame(5);
  endtask

  task automatic test_backpressure();
    setup_frame(1, gaussian_coef(1), 6, 4, 4);
    hold_cycles = 3000;
    send_frame(0);
    // hold the sender until everything is out
    in_tvalid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk);
    send_frame(3);
  endtask

  task automatic test_random_frames(int target);
    int w, h, base;
    bit first;
    base = items_sent;
    first = 1;
    while (items_sent < target) begin
      if (first || $urandom_range(99) < 60) begin
        w = ($urandom_range(9) == 0) ? $urandom_range(40, 17) : $urandom_range(12, 1);
        h = ($urandom_range(9) == 0) ? $urandom_range(20, 7) : $urandom_range(6, 1);
        setup_frame($urandom_range(7), ($urandom_range(3) == 0) ?
                    {$urandom(), $urandom()} : gaussian_coef(7), w, h, $urandom_range(7));
      end
      first = 0;
      quiet = (items_sent >= base + 50) && (items_sent < base + 200);
      send_frame(($urandom_range(3) == 0) ? 8 : 0);
    end
    quiet = 0;
  endtask

  initial begin
    rad_reg = RST_RADIUS;
    coef_reg = RST_COEF;
    width_reg = RST_WIDTH;
    height_reg = RST_HEIGHT;
    comps_reg = RST_COMPS;
    col_pos = 0;
    row_pos = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_config_mid_frame();
    test_backpressure();
    test_wide_line();
    test_random_frames(1350);
    in_tvalid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk);
    repeat (cur_width() * 40 + 100) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
